// ===== src/ihdgs_pkg.sv =====
// ----------------------------------------------------------------------------
// ihdgs_pkg
// Shared types, constants and helpers for the implicit heat diffusion solver.
// ----------------------------------------------------------------------------
package ihdgs_pkg;

  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_SWEEPS = 4096;
  localparam int MAX_STEPS  = 65535;
  localparam int STRIDE     = MAX_ROWS + 1;
  localparam int CELLS      = (MAX_COLS + 1) * STRIDE;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int SWEEP_W    = 13;
  localparam int STEP_W     = 16;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef enum logic [2:0] {
    CFG_COLS     = 3'd0,
    CFG_ROWS     = 3'd1,
    CFG_COEF_EW  = 3'd2,
    CFG_COEF_NS  = 3'd3,
    CFG_COEF_T   = 3'd4,
    CFG_RECIP    = 3'd5,
    CFG_INNER    = 3'd6,
    CFG_OUTER    = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    KIND_SOLVE = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] col;
    logic [6:0] row;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic [15:0]        steps_done;
    logic [12:0]        last_sweeps;
    logic               converged;
  } out_t;

  typedef enum logic [2:0] {
    W_HOLD, W_FULL_START, W_INNER_START, W_FULL_NEXT, W_INNER_NEXT, W_LOAD_IN
  } walk_t;

  typedef enum logic [2:0] {
    A_K, A_E, A_W, A_N, A_S
  } addr_t;

  typedef enum logic [2:0] {
    M_NONE, M_EW, M_NS, M_TIME, M_RLO, M_RHI, M_SQ
  } mul_t;

  typedef struct packed {
    walk_t walk;
    logic  now_rd;
    addr_t now_sel;
    logic  prev_rd;
    logic  init_wr;
    logic  nv_wr;
    logic  prev_wr;
    mul_t  mul;
    logic  diff_mem;
    logic  num_clr;
    logic  num_add;
    logic  old_ld;
    logic  qlo_ld;
    logic  err_clr;
    logic  err_add;
    logic  swp_clr;
    logic  swp_inc;
    logic  stp_clr;
    logic  stp_inc;
    logic  fin;
    logic  ok;
    logic  tmp_ld;
    logic  tmp_rd;
    logic  out_ld;
  } cmd_t;

  typedef struct packed {
    logic full_last;
    logic inner_last;
    logic inner_ok;
    logic outer_ok;
    logic sweep_cap;
    logic step_cap;
    logic out_free;
  } stat_t;

  function automatic logic [6:0] clamp_dim(logic [6:0] v, logic [6:0] maxv);
    logic [6:0] r;
    if (v < 7'd2) begin
      r = 7'd2;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

// ===== src/ihdgs_dp.sv =====
// ----------------------------------------------------------------------------
// ihdgs_dp
// Datapath: grid memories, cell walk counters, shared multiplier, accumulators.
// ----------------------------------------------------------------------------
module ihdgs_dp
  import ihdgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  in_t         in_item,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_item
);

  logic [6:0]  cols_used, rows_used;
  logic [31:0] coef_ew, coef_ns, coef_time, center_recip;
  logic [62:0] inner_limit, outer_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_used    <= 7'd32;
      rows_used    <= 7'd32;
      coef_ew      <= 32'd65536;
      coef_ns      <= 32'd65536;
      coef_time    <= 32'd6400000;
      center_recip <= 32'd42249908;
      inner_limit  <= 63'd118059162071;
      outer_limit  <= 63'd118059;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_COLS:    cols_used    <= cfg_data[6:0];
        CFG_ROWS:    rows_used    <= cfg_data[6:0];
        CFG_COEF_EW: coef_ew      <= cfg_data[31:0];
        CFG_COEF_NS: coef_ns      <= cfg_data[31:0];
        CFG_COEF_T:  coef_time    <= cfg_data[31:0];
        CFG_RECIP:   center_recip <= cfg_data[31:0];
        CFG_INNER:   inner_limit  <= cfg_data;
        CFG_OUTER:   outer_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [6:0] cols, rows;
  assign cols = clamp_dim(cols_used, 7'(MAX_COLS));
  assign rows = clamp_dim(rows_used, 7'(MAX_ROWS));

  // cell walk
  logic [6:0] ci, cj;
  logic       rd_ok;
  logic       in_range;
  assign in_range = (in_item.col <= cols) && (in_item.row <= rows);

  always_ff @(posedge clk) begin
    case (cmd.walk)
      W_FULL_START: begin
        ci <= 7'd0;
        cj <= 7'd0;
      end
      W_INNER_START: begin
        ci <= 7'd1;
        cj <= 7'd1;
      end
      W_FULL_NEXT: begin
        if (cj == rows) begin
          cj <= 7'd0;
          ci <= ci + 7'd1;
        end else begin
          cj <= cj + 7'd1;
        end
      end
      W_INNER_NEXT: begin
        if (cj == rows - 7'd1) begin
          cj <= 7'd1;
          ci <= ci + 7'd1;
        end else begin
          cj <= cj + 7'd1;
        end
      end
      W_LOAD_IN: begin
        ci    <= in_range ? in_item.col : 7'd0;
        cj    <= in_range ? in_item.row : 7'd0;
        rd_ok <= in_range;
      end
      default: ;
    endcase
  end

  logic [13:0]       k_full;
  logic [ADDR_W-1:0] k, rd_addr;
  assign k_full = 14'(ci) * 14'(STRIDE) + 14'(cj);
  assign k      = k_full[ADDR_W-1:0];

  always_comb begin
    case (cmd.now_sel)
      A_E:     rd_addr = k + ADDR_W'(STRIDE);
      A_W:     rd_addr = k - ADDR_W'(STRIDE);
      A_N:     rd_addr = k + ADDR_W'(1);
      A_S:     rd_addr = k - ADDR_W'(1);
      default: rd_addr = k;
    endcase
  end

  // grid memories
  logic signed [31:0] now_mem  [CELLS];
  logic signed [31:0] prev_mem [CELLS];
  logic signed [31:0] now_q, prev_q, nv, old, nv_c, now_wd;
  logic               now_we;

  assign now_we = cmd.init_wr || cmd.nv_wr;
  assign now_wd = cmd.init_wr ? ((cj == rows) ? ONE_Q30 : 32'd0) : nv_c;

  always_ff @(posedge clk) begin
    if (now_we) now_mem[k] <= now_wd;
    if (cmd.now_rd) now_q <= now_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.prev_wr) prev_mem[k] <= now_q;
    if (cmd.prev_rd) prev_q <= prev_mem[k];
  end

  // shared multiplier
  logic signed [51:0] num;
  logic [50:0]        num_mag;
  logic signed [32:0] diff;
  logic [32:0]        dmag;
  logic [32:0]        mul_a, mul_b;
  logic               neg_c, mul_neg;
  logic [65:0]        prod;
  logic [31:0]        qlo;
  logic [63:0]        q;

  assign num_mag = num[51] ? 51'(-num) : num[50:0];
  assign diff = cmd.diff_mem ? (33'(now_q) - 33'(prev_q)) : (33'(nv) - 33'(old));
  assign dmag = diff[32] ? 33'(-diff) : 33'(diff);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    neg_c = 1'b0;
    case (cmd.mul)
      M_EW: begin
        mul_a = {1'b0, coef_ew};
        mul_b = {1'b0, abs32(now_q)};
        neg_c = now_q[31];
      end
      M_NS: begin
        mul_a = {1'b0, coef_ns};
        mul_b = {1'b0, abs32(now_q)};
        neg_c = now_q[31];
      end
      M_TIME: begin
        mul_a = {1'b0, coef_time};
        mul_b = {1'b0, abs32(prev_q)};
        neg_c = prev_q[31];
      end
      M_RLO: begin
        mul_a = {1'b0, center_recip};
        mul_b = {1'b0, num_mag[31:0]};
      end
      M_RHI: begin
        mul_a = {1'b0, center_recip};
        mul_b = {14'd0, num_mag[50:32]};
      end
      M_SQ: begin
        mul_a = dmag;
        mul_b = dmag;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul != M_NONE) begin
      prod    <= {33'd0, mul_a} * {33'd0, mul_b};
      mul_neg <= neg_c;
    end
  end

  logic signed [51:0] term;
  assign term = signed'({4'd0, prod[63:16]});

  always_ff @(posedge clk) begin
    if (cmd.num_clr) num <= '0;
    else if (cmd.num_add) num <= mul_neg ? num - term : num + term;
    if (cmd.qlo_ld) qlo <= prod[63:32];
    if (cmd.old_ld) old <= now_q;
    if (cmd.nv_wr) nv <= nv_c;
  end

  assign q = prod[63:0] + {32'd0, qlo};

  always_comb begin
    if (num[51]) begin
      nv_c = (q >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q[31:0]);
    end else begin
      nv_c = (q > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(q[31:0]);
    end
  end

  // squared change accumulator
  logic [63:0] err;
  logic [64:0] err_sum;
  assign err_sum = {1'b0, err} + {1'b0, prod[63:0]};

  always_ff @(posedge clk) begin
    if (cmd.err_clr) err <= '0;
    else if (cmd.err_add) err <= err_sum[64] ? '1 : err_sum[63:0];
  end

  // counters and results
  logic [SWEEP_W-1:0] sweeps, sweep_total;
  logic [STEP_W-1:0]  steps, step_total;
  logic               done_ok;
  logic signed [31:0] tmp;

  always_ff @(posedge clk) begin
    if (cmd.swp_clr) sweeps <= '0;
    else if (cmd.swp_inc) sweeps <= sweeps + SWEEP_W'(1);
    if (cmd.stp_clr) steps <= '0;
    else if (cmd.stp_inc) steps <= steps + STEP_W'(1);
    if (cmd.tmp_ld) tmp <= (cmd.tmp_rd && rd_ok) ? now_q : 32'sd0;
    if (cmd.out_ld) begin
      out_item.temperature <= tmp;
      out_item.steps_done  <= step_total;
      out_item.last_sweeps <= sweep_total;
      out_item.converged   <= done_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_total  <= '0;
      sweep_total <= '0;
      done_ok     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.fin) begin
        step_total  <= steps;
        sweep_total <= sweeps;
        done_ok     <= cmd.ok;
      end
      if (cmd.out_ld) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign stat.full_last  = (ci == cols) && (cj == rows);
  assign stat.inner_last = (ci == cols - 7'd1) && (cj == rows - 7'd1);
  assign stat.inner_ok   = err <= {1'b0, inner_limit};
  assign stat.outer_ok   = err <= {1'b0, outer_limit};
  assign stat.sweep_cap  = sweeps >= SWEEP_W'(MAX_SWEEPS - 1);
  assign stat.step_cap   = steps >= STEP_W'(MAX_STEPS);
  assign stat.out_free   = !out_valid || out_ready;

  a_inner_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk == W_INNER_NEXT && !stat.inner_last) |=> (ci >= 7'd1 && ci < cols))
    else $error("inner walk left the interior");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.swp_inc |=> (sweeps <= SWEEP_W'(MAX_SWEEPS)))
    else $error("sweep count past cap");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("result changed while waiting");

endmodule

// ===== src/ihdgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ihdgs_ctrl
// Controller: sequences init, copy, Gauss-Seidel sweeps, step check and reads.
// ----------------------------------------------------------------------------
module ihdgs_ctrl
  import ihdgs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_kind,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [24:0] {
    S_IDLE   = 25'd1 << 0,
    S_INIT   = 25'd1 << 1,
    S_CP_RD  = 25'd1 << 2,
    S_CP_WR  = 25'd1 << 3,
    S_CELL0  = 25'd1 << 4,
    S_CELL1  = 25'd1 << 5,
    S_CELL2  = 25'd1 << 6,
    S_CELL3  = 25'd1 << 7,
    S_CELL4  = 25'd1 << 8,
    S_CELL5  = 25'd1 << 9,
    S_CELL6  = 25'd1 << 10,
    S_CELL7  = 25'd1 << 11,
    S_CELL8  = 25'd1 << 12,
    S_CELL9  = 25'd1 << 13,
    S_CELL10 = 25'd1 << 14,
    S_CELL11 = 25'd1 << 15,
    S_SW_END = 25'd1 << 16,
    S_O_RD   = 25'd1 << 17,
    S_O_MUL  = 25'd1 << 18,
    S_O_ACC  = 25'd1 << 19,
    S_O_END  = 25'd1 << 20,
    S_FIN    = 25'd1 << 21,
    S_RD     = 25'd1 << 22,
    S_RDW    = 25'd1 << 23,
    S_EMIT   = 25'd1 << 24
  } state_t;

  state_t state, state_next;

  // S_FIN carries the ok bit from S_O_END
  logic ok_hold;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.walk    = W_HOLD;
    cmd.now_sel = A_K;
    cmd.mul     = M_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind_t'(in_kind) == KIND_SOLVE) begin
            cmd.walk    = W_FULL_START;
            cmd.stp_clr = 1'b1;
            state_next  = S_INIT;
          end else begin
            cmd.walk   = W_LOAD_IN;
            state_next = S_RD;
          end
        end
      end
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.full_last) begin
          cmd.walk   = W_INNER_START;
          state_next = S_CP_RD;
        end else begin
          cmd.walk = W_FULL_NEXT;
        end
      end
      S_CP_RD: begin
        cmd.now_rd = 1'b1;
        state_next = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.prev_wr = 1'b1;
        if (stat.inner_last) begin
          cmd.walk    = W_INNER_START;
          cmd.err_clr = 1'b1;
          cmd.swp_clr = 1'b1;
          state_next  = S_CELL0;
        end else begin
          cmd.walk   = W_INNER_NEXT;
          state_next = S_CP_RD;
        end
      end
      S_CELL0: begin
        cmd.now_rd  = 1'b1;
        cmd.now_sel = A_E;
        cmd.prev_rd = 1'b1;
        state_next  = S_CELL1;
      end
      S_CELL1: begin
        cmd.now_rd  = 1'b1;
        cmd.now_sel = A_W;
        cmd.mul     = M_EW;
        cmd.num_clr = 1'b1;
        state_next  = S_CELL2;
      end
      S_CELL2: begin
        cmd.now_rd  = 1'b1;
        cmd.now_sel = A_N;
        cmd.mul     = M_EW;
        cmd.num_add = 1'b1;
        state_next  = S_CELL3;
      end
      S_CELL3: begin
        cmd.now_rd  = 1'b1;
        cmd.now_sel = A_S;
        cmd.mul     = M_NS;
        cmd.num_add = 1'b1;
        state_next  = S_CELL4;
      end
      S_CELL4: begin
        cmd.now_rd  = 1'b1;
        cmd.now_sel = A_K;
        cmd.mul     = M_NS;
        cmd.num_add = 1'b1;
        state_next  = S_CELL5;
      end
      S_CELL5: begin
        cmd.mul     = M_TIME;
        cmd.num_add = 1'b1;
        cmd.old_ld  = 1'b1;
        state_next  = S_CELL6;
      end
      S_CELL6: begin
        cmd.num_add = 1'b1;
        state_next  = S_CELL7;
      end
      S_CELL7: begin
        cmd.mul    = M_RLO;
        state_next = S_CELL8;
      end
      S_CELL8: begin
        cmd.mul    = M_RHI;
        cmd.qlo_ld = 1'b1;
        state_next = S_CELL9;
      end
      S_CELL9: begin
        cmd.nv_wr  = 1'b1;
        state_next = S_CELL10;
      end
      S_CELL10: begin
        cmd.mul    = M_SQ;
        state_next = S_CELL11;
      end
      S_CELL11: begin
        cmd.err_add = 1'b1;
        if (stat.inner_last) begin
          state_next = S_SW_END;
        end else begin
          cmd.walk   = W_INNER_NEXT;
          state_next = S_CELL0;
        end
      end
      S_SW_END: begin
        cmd.swp_inc = 1'b1;
        if (stat.inner_ok || stat.sweep_cap) begin
          cmd.stp_inc = 1'b1;
          if (!stat.inner_ok) begin
            state_next = S_FIN;
          end else begin
            cmd.walk    = W_INNER_START;
            cmd.err_clr = 1'b1;
            state_next  = S_O_RD;
          end
        end else begin
          cmd.walk    = W_INNER_START;
          cmd.err_clr = 1'b1;
          state_next  = S_CELL0;
        end
      end
      S_O_RD: begin
        cmd.now_rd  = 1'b1;
        cmd.prev_rd = 1'b1;
        state_next  = S_O_MUL;
      end
      S_O_MUL: begin
        cmd.mul      = M_SQ;
        cmd.diff_mem = 1'b1;
        state_next   = S_O_ACC;
      end
      S_O_ACC: begin
        cmd.err_add = 1'b1;
        if (stat.inner_last) begin
          state_next = S_O_END;
        end else begin
          cmd.walk   = W_INNER_NEXT;
          state_next = S_O_RD;
        end
      end
      S_O_END: begin
        if (stat.outer_ok) begin
          state_next = S_FIN;
        end else if (stat.step_cap) begin
          state_next = S_FIN;
        end else begin
          cmd.walk   = W_INNER_START;
          state_next = S_CP_RD;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        cmd.ok     = ok_hold;
        cmd.tmp_ld = 1'b1;
        state_next = S_EMIT;
      end
      S_RD: begin
        cmd.now_rd = 1'b1;
        state_next = S_RDW;
      end
      S_RDW: begin
        cmd.tmp_ld = 1'b1;
        cmd.tmp_rd = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_O_END) ok_hold <= stat.outer_ok;
    else if (state == S_SW_END) ok_hold <= 1'b0;
  end

  assign_fin: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("item accepted without leaving idle");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !stat.out_free) |=> (state == S_EMIT))
    else $error("result dropped while output busy");

  a_fin_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (state == S_EMIT))
    else $error("solve finish did not emit");

endmodule

// ===== src/implicit_heat_diffusion_grid_solver.sv =====
// ----------------------------------------------------------------------------
// implicit_heat_diffusion_grid_solver
// Implicit 2-D plate heat diffusion solved by Gauss-Seidel sweeps to steady state.
// ----------------------------------------------------------------------------
// Read item: the cell is read in S_RD and S_RDW; the result is loaded in S_EMIT.
// Solve item: all cells are initialised, then per time step each interior cell is
//   copied (S_CP_RD, S_CP_WR), swept in S_CELL0..S_CELL11 plus S_SW_END per sweep
//   (shared multiplier, single grid read port), and checked in S_O_RD..S_O_END.
// One item at a time; the next item is taken while a result waits on the output.
// Reset idles control, reloads config, clears out_valid; grid memories are not cleared.
module implicit_heat_diffusion_grid_solver
  import ihdgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_item,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  ihdgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (in_item.kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ihdgs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
